// ----- hw/rtl/binary_morphology_filter_top_macros.svh -----
// ----------------------------------------------------------------------------
// binary morphology filter assertion macros
// shared property forms for the filter checks
// ----------------------------------------------------------------------------
`ifndef BINARY_MORPHOLOGY_FILTER_TOP_MACROS_SVH
`define BINARY_MORPHOLOGY_FILTER_TOP_MACROS_SVH

// consequent holds in the same cycle
`define BMF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the following cycle
`define BMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmf_pkg
// shared types and constants of the binary morphology filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmf_pkg;
  localparam int GRAY_W     = 8;
  localparam int COORD_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int MASK_W     = 25;
  localparam int SIZE_W     = 11;
  localparam int MODE_W     = 2;
  localparam int MIN_SIZE   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_OP_MODE      = 3'd1,
    REG_STRUCT_MASK  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_DILATE = 2'd0,
    MODE_ERODE  = 2'd1,
    MODE_OPEN   = 2'd2,
    MODE_CLOSE  = 2'd3
  } mode_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [GRAY_W-1:0] THRESHOLD_RST = 8'd128;
  localparam logic [MASK_W-1:0] MASK_RST      = 25'd15728622;
  localparam logic [SIZE_W-1:0] SIZE_RST      = 11'd512;

  typedef struct packed {
    logic              erode;
    logic [MASK_W-1:0] mask;
  } pass_ctl_t;
endpackage

// ----- hw/rtl/bmf_in_if.sv -----
// ----------------------------------------------------------------------------
// bmf_in_if
// pixel request channel: kind and gray sample
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmf_in_if;
  import bmf_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [GRAY_W-1:0] gray_pixel;

  modport source (output valid, output kind, output gray_pixel, input ready);
  modport sink (input valid, input kind, input gray_pixel, output ready);
endinterface

// ----- hw/rtl/bmf_out_if.sv -----
// ----------------------------------------------------------------------------
// bmf_out_if
// result channel: binary pixel with its position
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmf_out_if;
  import bmf_pkg::*;
  logic               valid;
  logic               ready;
  logic               out_pixel;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               frame_last;

  modport source (output valid, output out_pixel, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink (input valid, input out_pixel, input out_row, input out_col,
                input frame_last, output ready);
endinterface

// ----- hw/rtl/bmf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// bmf_cfg_if
// register write channel: index and data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmf_cfg_if;
  import bmf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/bmf_ram.sv -----
// ----------------------------------------------------------------------------
// bmf_ram
// generic single-clock ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ----- hw/rtl/bmf_pass.sv -----
// ----------------------------------------------------------------------------
// bmf_pass
// one dilation or erosion pass: line memory, square window, masked combine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmf_pass #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int SPAN       = 5,
  localparam int HALF  = SPAN / 2,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int LW_W  = $clog2(MAX_WIDTH + 1),
  localparam int LH_W  = $clog2(MAX_HEIGHT + 1),
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2 * HALF + 2)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic              in_bit,
  input  logic              in_first,
  input  bmf_pkg::pass_ctl_t ctl,
  input  logic [LW_W-1:0]   img_w,
  input  logic [LH_W-1:0]   img_h,
  output logic              busy,
  output logic              out_valid,
  output logic              out_bit,
  output logic [ROW_W-1:0]  out_row,
  output logic [COL_W-1:0]  out_col
);
  import bmf_pkg::*;

  localparam int TAPS  = SPAN - 1;
  localparam int CELLS = SPAN * SPAN;

  logic [COL_W-1:0] icol_r, icol_nxt, cur_col;
  logic [ROW_W-1:0] irow_r, irow_nxt, cur_row;
  logic             row_ok, emit_in;
  logic             a_valid_r, a_bit_r, a_emit_r, a_first_r;
  logic [COL_W-1:0] a_col_r;
  logic [TAPS-1:0]  tap, tap_wr;
  logic [CELLS-1:0] win_r, win_nxt, vis;
  logic             b_valid_r;
  logic [ROW_W-1:0] crow_r, crow_nxt, b_row_r;
  logic [COL_W-1:0] ccol_r, ccol_nxt, b_col_r;
  logic             dil, ero;

  // position of the incoming item
  always_comb begin
    cur_col = in_first ? '0 : icol_r;
    cur_row = in_first ? '0 : irow_r;
    row_ok  = cur_row < ROW_W'(img_h);
    emit_in = (cur_row > ROW_W'(HALF)) ||
              ((cur_row == ROW_W'(HALF)) && (cur_col >= COL_W'(HALF)));
    if (LW_W'(cur_col) + LW_W'(1) == img_w) begin
      icol_nxt = '0;
      irow_nxt = cur_row + ROW_W'(1);
    end else begin
      icol_nxt = cur_col + COL_W'(1);
      irow_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icol_r    <= '0;
      irow_r    <= '0;
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      if (in_valid) begin
        icol_r <= icol_nxt;
        irow_r <= irow_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_bit_r   <= in_bit & row_ok;
      a_emit_r  <= emit_in;
      a_first_r <= in_first;
      a_col_r   <= cur_col;
    end
  end

  // line memory holds the older rows of each column
  assign tap_wr = {tap[TAPS-2:0], a_bit_r};

  bmf_ram #(
    .WIDTH (TAPS),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .we      (en && a_valid_r),
    .waddr   (a_col_r),
    .wdata   (tap_wr),
    .re      (en),
    .raddr   (cur_col),
    .rd_data (tap)
  );

  always_comb begin
    for (int x = 0; x < SPAN - 1; x++) begin
      win_nxt[x*SPAN +: SPAN] = win_r[(x+1)*SPAN +: SPAN];
    end
    win_nxt[(SPAN-1)*SPAN +: SPAN] = {tap, a_bit_r};
    if (LW_W'(ccol_r) + LW_W'(1) == img_w) begin
      ccol_nxt = '0;
      crow_nxt = crow_r + ROW_W'(1);
    end else begin
      ccol_nxt = ccol_r + COL_W'(1);
      crow_nxt = crow_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      crow_r    <= '0;
      ccol_r    <= '0;
    end else if (en) begin
      b_valid_r <= a_valid_r && a_emit_r;
      if (a_valid_r) begin
        if (a_first_r) begin
          crow_r <= '0;
          ccol_r <= '0;
        end else if (a_emit_r) begin
          crow_r <= crow_nxt;
          ccol_r <= ccol_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && a_valid_r) begin
      win_r <= win_nxt;
      if (a_emit_r) begin
        b_row_r <= crow_r;
        b_col_r <= ccol_r;
      end
    end
  end

  // masked combine around the centre
  always_comb begin
    int  dx;
    int  dy;
    int  b;
    logic row_in;
    logic col_in;
    logic mbit;
    dil = 1'b0;
    ero = 1'b1;
    for (int x = 0; x < SPAN; x++) begin
      for (int j = 0; j < SPAN; j++) begin
        dx = x - HALF;
        dy = HALF - j;
        row_in = (dy >= 0) || (int'(b_row_r) >= -dy);
        col_in = (dx < 0) ? (int'(b_col_r) >= -dx) : (int'(b_col_r) + dx < int'(img_w));
        vis[x*SPAN+j] = win_r[x*SPAN+j] & row_in & col_in;
      end
    end
    for (int x = 0; x < SPAN; x++) begin
      for (int j = 0; j < SPAN; j++) begin
        b = (SPAN - 1 - j) * SPAN + x;
        if (b < MASK_W) begin
          mbit = ctl.mask[b];
        end else begin
          mbit = 1'b0;
        end
        dil = dil | (mbit & vis[(SPAN-1-x)*SPAN + (SPAN-1-j)]);
        ero = ero & (~mbit | vis[x*SPAN+j]);
      end
    end
    ero = ero & vis[HALF*SPAN+HALF];
  end

  assign busy      = a_valid_r | b_valid_r;
  assign out_valid = b_valid_r;
  assign out_bit   = ctl.erode ? ero : dil;
  assign out_row   = b_row_r;
  assign out_col   = b_col_r;
endmodule

// ----- hw/rtl/binary_morphology_filter_top.sv -----
// ----------------------------------------------------------------------------
// binary_morphology_filter_top
// thresholded binary dilation, erosion, opening and closing on a pixel stream
// ----------------------------------------------------------------------------
// The block takes one request per clock while the output does not stall and
// no new image waits for the passes to drain, and returns at most one binary
// pixel per request, through one pass for dilation and erosion and two for
// opening and closing, one pass memory pipeline per morphology pass; the
// line memory of each pass is MAX_WIDTH deep and is read and written at most
// once per clock. At the first pixel of an image the request waits until both
// passes have drained, once per image; registers are sampled at that pixel.
`timescale 1ns / 1ps
`include "binary_morphology_filter_top_macros.svh"

module binary_morphology_filter_top #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 1024,
  parameter int ELEMENT_SPAN = 5
) (
  input logic        clk,
  input logic        rst_n,
  bmf_in_if.sink     in_req,
  bmf_out_if.source  out_res,
  bmf_cfg_if.sink    cfg_wr
);
  import bmf_pkg::*;

  localparam int HALF  = ELEMENT_SPAN / 2;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LW_W  = $clog2(MAX_WIDTH + 1);
  localparam int LH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2 * HALF + 2);

  logic [GRAY_W-1:0] thr_r, lat_thr_r, thr_use;
  mode_t             mode_r, lat_mode_r;
  logic [MASK_W-1:0] mask_r, lat_mask_r;
  logic [SIZE_W-1:0] width_r, height_r;
  logic [LW_W-1:0]   cw, lat_w_r;
  logic [LH_W-1:0]   ch, lat_h_r;
  logic [ROW_W-1:0]  end_row_nxt, end_row_r, vr_r, vr_nxt;
  logic [COL_W-1:0]  end_col_nxt, end_col_r, vc_r, vc_nxt;

  logic en, in_ready, acc, is_pix, at_start, at_end, row_in, adv, pix_bit, busy;
  logic two_pass;
  pass_ctl_t ctl1, ctl2;

  logic             p1_busy, p1_valid, p1_bit;
  logic [ROW_W-1:0] p1_row;
  logic [COL_W-1:0] p1_col;
  logic             p2_busy, p2_valid, p2_bit;
  logic [ROW_W-1:0] p2_row;
  logic [COL_W-1:0] p2_col;

  logic             fin_valid, fin_bit;
  logic [ROW_W-1:0] fin_row;
  logic [COL_W-1:0] fin_col;

  logic               out_valid_r, out_pixel_r, out_last_r;
  logic [COORD_W-1:0] out_row_r, out_col_r;

  // register writes
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THRESHOLD_RST;
      mode_r   <= MODE_DILATE;
      mask_r   <= MASK_RST;
      width_r  <= SIZE_RST;
      height_r <= SIZE_RST;
    end else if (cfg_wr.valid) begin
      unique case (reg_idx_t'(cfg_wr.index))
        REG_THRESHOLD:    thr_r    <= cfg_wr.data[GRAY_W-1:0];
        REG_OP_MODE:      mode_r   <= mode_t'(cfg_wr.data[MODE_W-1:0]);
        REG_STRUCT_MASK:  mask_r   <= cfg_wr.data[MASK_W-1:0];
        REG_IMAGE_WIDTH:  width_r  <= cfg_wr.data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wr.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // frame settings sampled at the first pixel
  always_comb begin
    int extra;
    if (int'(width_r) < MIN_SIZE) begin
      cw = LW_W'(MIN_SIZE);
    end else if (int'(width_r) > MAX_WIDTH) begin
      cw = LW_W'(MAX_WIDTH);
    end else begin
      cw = LW_W'(width_r);
    end
    if (int'(height_r) < MIN_SIZE) begin
      ch = LH_W'(MIN_SIZE);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      ch = LH_W'(MAX_HEIGHT);
    end else begin
      ch = LH_W'(height_r);
    end
    extra = (mode_r == MODE_OPEN || mode_r == MODE_CLOSE) ? 2 * HALF : HALF;
    if (extra - 1 >= int'(cw)) begin
      end_row_nxt = ROW_W'(ch) + ROW_W'(extra + 1);
      end_col_nxt = COL_W'(extra - 1 - int'(cw));
    end else begin
      end_row_nxt = ROW_W'(ch) + ROW_W'(extra);
      end_col_nxt = COL_W'(extra - 1);
    end
  end

  // request front end
  assign en       = !out_valid_r || out_res.ready;
  assign busy     = p1_busy | p2_busy;
  assign at_start = (vr_r == '0) && (vc_r == '0);
  assign in_ready = en && !(at_start && busy);
  assign acc      = in_req.valid && in_ready;
  assign is_pix   = in_req.kind == KIND_PIXEL;
  assign row_in   = vr_r < ROW_W'(lat_h_r);
  assign at_end   = (vr_r == end_row_r) && (vc_r == end_col_r);
  assign thr_use  = at_start ? thr_r : lat_thr_r;
  assign pix_bit  = is_pix && (in_req.gray_pixel >= thr_use);
  assign in_req.ready = in_ready;

  always_comb begin
    if (at_start) begin
      adv = acc && is_pix;
    end else begin
      adv = acc && (is_pix ? row_in : !row_in);
    end
    if (!at_start && at_end) begin
      vr_nxt = '0;
      vc_nxt = '0;
    end else if (LW_W'(vc_r) + LW_W'(1) == lat_w_r) begin
      vr_nxt = vr_r + ROW_W'(1);
      vc_nxt = '0;
    end else begin
      vr_nxt = vr_r;
      vc_nxt = vc_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_r       <= '0;
      vc_r       <= '0;
      lat_w_r    <= LW_W'(MIN_SIZE);
      lat_h_r    <= LH_W'(MIN_SIZE);
      lat_mode_r <= MODE_DILATE;
    end else if (adv) begin
      vr_r <= vr_nxt;
      vc_r <= vc_nxt;
      if (at_start) begin
        lat_w_r    <= cw;
        lat_h_r    <= ch;
        lat_mode_r <= mode_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && at_start) begin
      lat_thr_r  <= thr_r;
      lat_mask_r <= mask_r;
      end_row_r  <= end_row_nxt;
      end_col_r  <= end_col_nxt;
    end
  end

  // passes
  assign two_pass   = (lat_mode_r == MODE_OPEN) || (lat_mode_r == MODE_CLOSE);
  assign ctl1.erode = (lat_mode_r == MODE_ERODE) || (lat_mode_r == MODE_OPEN);
  assign ctl1.mask  = lat_mask_r;
  assign ctl2.erode = lat_mode_r == MODE_CLOSE;
  assign ctl2.mask  = lat_mask_r;

  bmf_pass #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .SPAN       (ELEMENT_SPAN)
  ) u_pass1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (adv),
    .in_bit    (pix_bit),
    .in_first  (at_start),
    .ctl       (ctl1),
    .img_w     (lat_w_r),
    .img_h     (lat_h_r),
    .busy      (p1_busy),
    .out_valid (p1_valid),
    .out_bit   (p1_bit),
    .out_row   (p1_row),
    .out_col   (p1_col)
  );

  bmf_pass #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .SPAN       (ELEMENT_SPAN)
  ) u_pass2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p1_valid && two_pass),
    .in_bit    (p1_bit),
    .in_first  ((p1_row == '0) && (p1_col == '0)),
    .ctl       (ctl2),
    .img_w     (lat_w_r),
    .img_h     (lat_h_r),
    .busy      (p2_busy),
    .out_valid (p2_valid),
    .out_bit   (p2_bit),
    .out_row   (p2_row),
    .out_col   (p2_col)
  );

  assign fin_valid = two_pass ? p2_valid : p1_valid;
  assign fin_bit   = two_pass ? p2_bit : p1_bit;
  assign fin_row   = two_pass ? p2_row : p1_row;
  assign fin_col   = two_pass ? p2_col : p1_col;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pixel_r <= fin_bit;
      out_row_r   <= COORD_W'(fin_row);
      out_col_r   <= COORD_W'(fin_col);
      out_last_r  <= (fin_row == ROW_W'(lat_h_r - LH_W'(1))) &&
                     (fin_col == COL_W'(lat_w_r - LW_W'(1)));
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.out_pixel  = out_pixel_r;
  assign out_res.out_row    = out_row_r;
  assign out_res.out_col    = out_col_r;
  assign out_res.frame_last = out_last_r;

  `BMF_ASSERT_SAME(a_last_at_start, out_valid_r && out_last_r, at_start,
    "frame end shown while the front end is inside an image")
  `BMF_ASSERT_SAME(a_pos_in_image, out_valid_r,
    (int'(out_col_r) < int'(lat_w_r)) && (int'(out_row_r) < int'(lat_h_r)),
    "result position outside the image")
  `BMF_ASSERT_NEXT(a_bypass_lands, en && p1_valid && !two_pass, out_valid_r,
    "single pass result lost")
endmodule
